// ===== hw/rtl/ffat_pkg.sv =====
// Shared types and constants of the first-fit allocation table.
package ffat_pkg;

	// Field widths of the streams and the configuration port
	localparam int REQ_W       = 32;
	localparam int PTR_W       = 32;
	localparam int RES_ADDR_W  = 32;
	localparam int STATUS_W    = 2;
	localparam int CFG_W       = 32;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - RES_ADDR_W - STATUS_W;

	// A rounded size reaches 2^32, so it needs one bit more than the request
	localparam int SIZE_W = REQ_W + 1;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SIZE_W-1:0] size_t;

	// Request kinds
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOSPACE  = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	// Register indexes
	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	// Allocation granule is eight bytes
	localparam size_t SIZE_ROUND = 33'd7;

endpackage

// ===== hw/rtl/first_fit_allocation_table.sv =====
// First-fit allocation table: sorted block table in memory, walked and shifted in place.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser op, tdata request_size, block_address
//  m_axis    out        tvalid/tready          tdata result_address, status
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_wdata
//
// One request at a time. The table memory sets the pace: one entry is read per cycle
// during the walk, and one entry is moved per cycle while the table opens or closes a
// slot. Reset empties the table at once (count to zero, no clearing pass) and sets both
// heap registers to zero. A stalled result sits in the output register while the next
// request is already taken; only its completion waits for the slot.
module first_fit_allocation_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [ffat_pkg::CFG_W-1:0]            cfg_wdata,
	// request stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [ffat_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // request_size, block_address
	input  logic                                  s_axis_tuser,  // op
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [ffat_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // result_address, status, pad
);

	localparam int AB  = ADDRESS_BITS;
	localparam int IW  = $clog2(TABLE_ENTRIES);
	localparam int CW  = $clog2(TABLE_ENTRIES + 1);
	localparam int LW  = ffat_pkg::SIZE_W;
	// compare width: wide enough for any address difference and any size
	localparam int XW  = (AB > LW) ? AB : LW;
	localparam int XW1 = XW + 1;
	localparam logic [AB-1:0] AMASK = '1;
	localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_ENTRIES);

	// sequencer codes
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_FIT      = 3'd2;
	localparam logic [2:0] S_SHIFT_UP = 3'd3;
	localparam logic [2:0] S_SHIFT_DN = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	// table memory, one entry per held block, sorted by start address
	logic [AB-1:0] start_mem [TABLE_ENTRIES];
	logic [LW-1:0] len_mem   [TABLE_ENTRIES];

	logic [2:0]                  state_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               pos_q;     // entry whose read data is present
	logic [CW-1:0]               k_q;       // destination slot while moving entries
	logic                        out_valid_q;
	logic [ffat_pkg::CFG_W-1:0]  heap_base_q;
	logic [ffat_pkg::CFG_W-1:0]  heap_limit_q;

	// request and result payload
	logic                        op_q;
	ffat_pkg::size_t             size_q;
	logic [AB-1:0]               ptr_q;
	logic [AB-1:0]               cand_q;
	logic [AB-1:0]               res_addr_q;
	ffat_pkg::status_t           res_status_q;
	logic [ffat_pkg::RES_ADDR_W-1:0] out_addr_q;
	ffat_pkg::status_t           out_status_q;

	// memory read data
	logic [AB-1:0]               rd_start_q;
	logic [LW-1:0]               rd_len_q;

	logic                        accept;
	logic                        out_free;
	logic [AB-1:0]               base;
	logic [AB-1:0]               limit;
	ffat_pkg::size_t             req_size;
	logic [CW-1:0]               rd_cnt;
	logic [IW-1:0]               rd_addr;
	logic                        wr_en;
	logic [IW-1:0]               wr_addr;
	logic [AB-1:0]               wr_start;
	logic [LW-1:0]               wr_len;
	logic                        scan_full;
	logic                        scan_end;
	logic                        scan_brk;
	logic                        free_hit;
	logic [XW1-1:0]              end_sum;
	logic [AB-1:0]               ent_end;
	logic                        fit_bad;
	logic                        up_last;
	logic                        dn_last;
	logic [AB-1:0]               gap;
	logic [AB-1:0]               room;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{ffat_pkg::OUT_PAD_W{1'b0}}, out_status_q, out_addr_q};

	// heap window taken modulo the address space
	assign base  = AB'(64'(heap_base_q));
	assign limit = AB'(64'(heap_limit_q));

	// round the request up to the granule
	assign req_size = (ffat_pkg::size_t'(s_axis_tdata[ffat_pkg::REQ_W-1:0])
		+ ffat_pkg::SIZE_ROUND) & ~ffat_pkg::SIZE_ROUND;

	// walk: a gap before the entry fits when it lies at or above the candidate and holds the size
	assign gap       = rd_start_q - cand_q;
	assign scan_full = (op_q == ffat_pkg::OP_ALLOC) && (size_q != '0) && (count_q == CNT_FULL);
	assign scan_end  = (pos_q == count_q);
	assign scan_brk  = (cand_q <= rd_start_q) && (XW'(gap) >= XW'(size_q));
	assign free_hit  = (rd_start_q == ptr_q);

	// end of the entry, saturated at the top of the address space
	assign end_sum = XW1'(rd_start_q) + XW1'(rd_len_q);
	assign ent_end = (end_sum > XW1'(AMASK)) ? AMASK : end_sum[AB-1:0];

	// the found place must end at or below the heap limit
	assign room    = limit - cand_q;
	assign fit_bad = (cand_q > limit) || (XW'(room) < XW'(size_q));

	assign up_last = (k_q == pos_q);
	assign dn_last = (CW'(k_q + 1'b1) == count_q);

	// read address: one entry ahead of the walk, or the source of the next move
	always_comb begin
		case (state_q)
			S_SCAN:     rd_cnt = CW'(pos_q + 1'b1);
			S_FIT:      rd_cnt = CW'(count_q - 1'b1);
			S_SHIFT_UP: rd_cnt = CW'(k_q - 2'd2);
			S_SHIFT_DN: rd_cnt = CW'(k_q + 2'd2);
			default:    rd_cnt = '0;
		endcase
	end
	assign rd_addr = rd_cnt[IW-1:0];

	// write side: move one entry a cycle, drop the new block in at its place
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = k_q[IW-1:0];
		wr_start = rd_start_q;
		wr_len   = rd_len_q;
		case (state_q)
			S_SHIFT_UP: begin
				wr_en = 1'b1;
				if (up_last) begin
					wr_start = cand_q;
					wr_len   = size_q;
				end
			end
			S_SHIFT_DN: begin
				wr_en = !dn_last;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
			len_mem[wr_addr]   <= wr_len;
		end
		rd_start_q <= start_mem[rd_addr];
		rd_len_q   <= len_mem[rd_addr];
	end

	// sequencer, counters, output slot and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			heap_base_q  <= '0;
			heap_limit_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ffat_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata;
					ffat_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_wdata;
					default:                  heap_base_q  <= heap_base_q;
				endcase
			end
			// raise the slot when a result lands, drop it once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_full) begin
						state_q <= S_DONE;
					end else if (op_q == ffat_pkg::OP_ALLOC) begin
						if (scan_end || scan_brk) begin
							state_q <= S_FIT;
						end else begin
							pos_q <= CW'(pos_q + 1'b1);
						end
					end else begin
						if (scan_end) begin
							state_q <= S_DONE;
						end else if (free_hit) begin
							k_q     <= pos_q;
							state_q <= S_SHIFT_DN;
						end else begin
							pos_q <= CW'(pos_q + 1'b1);
						end
					end
				end
				S_FIT: begin
					if (fit_bad || size_q == '0) begin
						state_q <= S_DONE;
					end else begin
						k_q     <= count_q;
						state_q <= S_SHIFT_UP;
					end
				end
				S_SHIFT_UP: begin
					if (up_last) begin
						count_q <= CW'(count_q + 1'b1);
						state_q <= S_DONE;
					end else begin
						k_q <= CW'(k_q - 1'b1);
					end
				end
				S_SHIFT_DN: begin
					if (dn_last) begin
						count_q <= CW'(count_q - 1'b1);
						state_q <= S_DONE;
					end else begin
						k_q <= CW'(k_q + 1'b1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: request latch, running candidate, result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= s_axis_tuser;
					size_q       <= req_size;
					ptr_q        <= AB'(64'(s_axis_tdata[ffat_pkg::IN_TDATA_W-1:ffat_pkg::REQ_W]));
					cand_q       <= base;
					res_addr_q   <= '0;
					res_status_q <= ffat_pkg::ST_OK;
				end
			end
			S_SCAN: begin
				if (scan_full) begin
					res_status_q <= ffat_pkg::ST_FULL;
				end else if (op_q == ffat_pkg::OP_ALLOC) begin
					// advance the candidate past this entry
					if (!scan_end && !scan_brk && ent_end > cand_q) begin
						cand_q <= ent_end;
					end
				end else if (scan_end) begin
					res_status_q <= ffat_pkg::ST_NOTFOUND;
				end
			end
			S_FIT: begin
				if (fit_bad) begin
					res_status_q <= ffat_pkg::ST_NOSPACE;
				end else begin
					res_addr_q <= cand_q;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_addr_q   <= ffat_pkg::RES_ADDR_W'(64'(res_addr_q));
					out_status_q <= res_status_q;
				end
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

	// the table never holds more blocks than it has entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("block count beyond table size");

	// each request adds or removes at most one block
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == CW'($past(count_q) + 1'b1)
			|| count_q == CW'($past(count_q) - 1'b1)))
		else $error("block count jumped");

	// the table memory is written only while entries are being moved
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT_UP || state_q == S_SHIFT_DN))
		else $error("table written outside a move");

	// a full-table result only when every entry is taken
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == ffat_pkg::ST_FULL) |-> count_q == CNT_FULL)
		else $error("table full reported with free entries");

	// an unknown pointer can only come from a free request
	a_notfound_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == ffat_pkg::ST_NOTFOUND)
			|-> op_q == ffat_pkg::OP_FREE)
		else $error("pointer not found on an allocate");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the first-fit allocation table: directed table, random phases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = 64;
	localparam int N_STEPS = 24;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	// a request walks and shifts at most the whole table
	localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
	localparam int REPORT_CAP = 100;

	// what one request must give back
	typedef struct packed {
		logic [ffat_pkg::RES_ADDR_W-1:0] addr;
		ffat_pkg::status_t st;
	} reply_t;

	// one row of the directed table; reheap writes the heap registers before the item
	typedef struct packed {
		bit reheap;
		logic [ffat_pkg::CFG_W-1:0] base;
		logic [ffat_pkg::CFG_W-1:0] limit;
		logic op;
		logic [ffat_pkg::REQ_W-1:0] size;
		logic [ffat_pkg::PTR_W-1:0] ptr;
		bit typed;
		logic [ffat_pkg::RES_ADDR_W-1:0] want_addr;
		ffat_pkg::status_t want_st;
	} step_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = ffat_pkg::CFG_HEAP_BASE;
	logic [ffat_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ffat_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;  // request_size, block_address
	logic s_axis_tuser = ffat_pkg::OP_ALLOC;             // op
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ffat_pkg::OUT_TDATA_W-1:0] m_axis_tdata;      // result_address, status, pad

	// shadow of the heap registers and of the block table
	logic [ffat_pkg::CFG_W-1:0] heap_base_r = '0;
	logic [ffat_pkg::CFG_W-1:0] heap_limit_r = '0;
	logic [31:0] blk_start [TABLE_ENTRIES];
	logic [31:0] blk_len [TABLE_ENTRIES];
	int held = 0;

	reply_t awaited [$];
	int fails = 0;
	bit valid_held = 1'b0;
	int burst_left = 0;

	rx_mode_e rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;
	reply_t head;

	first_fit_allocation_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADDRESS_BITS(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Apply one request to the shadow table and return what the block must answer.
	// Allocate: round up to eight bytes, walk the sorted table from the heap base and
	// take the first gap that holds the block below the heap limit, then open a slot in address order.
	// Free: drop the entry that starts at the pointer and close the table up.
	function automatic reply_t serve_request(logic op, logic [ffat_pkg::REQ_W-1:0] size_req,
			logic [ffat_pkg::PTR_W-1:0] ptr);
		reply_t r;
		logic [32:0] need;
		logic [32:0] e;
		logic [31:0] cand;
		int pos;
		int k;
		r.addr = '0;
		r.st = ffat_pkg::ST_OK;
		if (op == ffat_pkg::OP_FREE) begin
			pos = held;
			for (k = 0; k < held; k++) begin
				if (blk_start[k] == ptr) begin
					pos = k;
					break;
				end
			end
			if (pos == held) begin
				r.st = ffat_pkg::ST_NOTFOUND;
			end else begin
				for (k = pos; k + 1 < held; k++) begin
					blk_start[k] = blk_start[k + 1];
					blk_len[k] = blk_len[k + 1];
				end
				held--;
			end
		end else begin
			need = ({1'b0, size_req} + ffat_pkg::SIZE_ROUND) & ~ffat_pkg::SIZE_ROUND;
			// a full table only matters for a request that would record something
			if (need != '0 && held >= TABLE_ENTRIES) begin
				r.st = ffat_pkg::ST_FULL;
			end else begin
				cand = heap_base_r;
				pos = 0;
				while (pos < held) begin
					if (cand <= blk_start[pos] &&
							({1'b0, blk_start[pos]} - {1'b0, cand}) >= need)
						break;
					// an entry end past the top of the address space saturates
					e = {1'b0, blk_start[pos]} + {1'b0, blk_len[pos]};
					if (e > 33'h0_FFFF_FFFF)
						e = 33'h0_FFFF_FFFF;
					if (e[31:0] > cand)
						cand = e[31:0];
					pos++;
				end
				if (cand > heap_limit_r || ({1'b0, heap_limit_r} - {1'b0, cand}) < need) begin
					r.st = ffat_pkg::ST_NOSPACE;
				end else begin
					r.addr = cand;
					// a zero-size request reports the address and records nothing
					if (need != '0) begin
						for (k = held; k > pos; k--) begin
							blk_start[k] = blk_start[k - 1];
							blk_len[k] = blk_len[k - 1];
						end
						blk_start[pos] = cand;
						blk_len[pos] = need[31:0];
						held++;
					end
				end
			end
		end
		return r;
	endfunction

	// Offer one item, wait for the handshake, then record what it must produce.
	// A typed expectation from the directed table stands in for the prediction,
	// but the shadow table is updated either way.
	task automatic push_item(input logic op, input logic [ffat_pkg::REQ_W-1:0] size_req,
			input logic [ffat_pkg::PTR_W-1:0] ptr, input bit typed, input reply_t want);
		reply_t p;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {ptr, size_req};
		valid_held = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		p = serve_request(op, size_req, ptr);
		awaited.push_back(typed ? want : p);
		// bursts of random length, most followed by a random gap; keep valid up inside a burst
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				valid_held = 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid and hold until every expected result has come, then let the block settle.
	task automatic quiesce(input int extra);
		if (valid_held) begin
			s_axis_tvalid <= 1'b0;
			valid_held = 1'b0;
		end
		while (awaited.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Write both heap registers on consecutive edges; only call with the block idle.
	task automatic write_heap(input logic [ffat_pkg::CFG_W-1:0] base,
			input logic [ffat_pkg::CFG_W-1:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= ffat_pkg::CFG_HEAP_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		heap_base_r = base;
		cfg_index <= ffat_pkg::CFG_HEAP_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		heap_limit_r = limit;
		cfg_we <= 1'b0;
	endtask

	// Receiver: switch between always ready, coin-toss stalls and a one-in-four trickle.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 2));
			rx_left <= $urandom_range(16, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
			default: m_axis_tready <= (rx_tick % 4 == 0);
		endcase
	end

	// Compare each accepted result with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited.size() == 0) begin
				fails++;
				if (fails <= REPORT_CAP)
					$error("unexpected result: result_address %h status %0d",
						m_axis_tdata[ffat_pkg::RES_ADDR_W-1:0],
						m_axis_tdata[ffat_pkg::RES_ADDR_W +: ffat_pkg::STATUS_W]);
			end else begin
				head = awaited.pop_front();
				if (m_axis_tdata[ffat_pkg::RES_ADDR_W-1:0] !== head.addr) begin
					fails++;
					if (fails <= REPORT_CAP)
						$error("result_address: expected %h, actual %h", head.addr,
							m_axis_tdata[ffat_pkg::RES_ADDR_W-1:0]);
				end
				if (m_axis_tdata[ffat_pkg::RES_ADDR_W +: ffat_pkg::STATUS_W] !== head.st) begin
					fails++;
					if (fails <= REPORT_CAP)
						$error("status: expected %0d, actual %0d", head.st,
							m_axis_tdata[ffat_pkg::RES_ADDR_W +: ffat_pkg::STATUS_W]);
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		step_t steps [N_STEPS];
		step_t row;
		logic [ffat_pkg::CFG_W-1:0] base;
		logic [ffat_pkg::CFG_W-1:0] limit;
		logic [32:0] sum;
		logic [32:0] span;
		logic [ffat_pkg::REQ_W-1:0] size_req;
		logic [ffat_pkg::PTR_W-1:0] ptr;
		logic op;
		int alloc_pct;
		int hold_at;
		int r;

		steps = '{
			// heap registers still at reset: base and limit both zero
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h1, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOSPACE},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOSPACE},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'h0, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOTFOUND},
			// small heap: pack three blocks, punch a hole, refill it exactly
			'{1'b1, 32'h100, 32'h200, ffat_pkg::OP_ALLOC, 32'h1, 32'hFFFF_FFFF, 1'b1, 32'h100,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h8, 32'h0, 1'b1, 32'h108,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h10, 32'h0, 1'b1, 32'h110,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'hFFFF_FFFF, 32'h108, 1'b1, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h5, 32'h0, 1'b1, 32'h108,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b0, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'h0, 32'h104, 1'b1, 32'h0,
				ffat_pkg::ST_NOTFOUND},
			// the rest of the heap, up to the limit exactly, then one granule too many
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'hE0, 32'h0, 1'b1, 32'h120,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h1, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOSPACE},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'h0, 32'h110, 1'b0, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h9, 32'h0, 1'b0, 32'h0,
				ffat_pkg::ST_OK},
			// heap at the top of the address space
			'{1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, ffat_pkg::OP_ALLOC, 32'h8, 32'h0, 1'b1,
				32'hFFFF_FFF0, ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h7, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOSPACE},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b0, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'h0, 32'hFFFF_FFF0, 1'b1, 32'h0,
				ffat_pkg::ST_OK},
			// base above the limit
			'{1'b1, 32'h10, 32'h8, ffat_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_NOSPACE},
			// whole address space; a size that rounds past 32 bits never fits
			'{1'b1, 32'h0, 32'hFFFF_FFFF, ffat_pkg::OP_ALLOC, 32'hFFFF_FFF9, 32'h0, 1'b1,
				32'h0, ffat_pkg::ST_NOSPACE},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'hF8, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_FREE, 32'h0, 32'h0, 1'b1, 32'h0,
				ffat_pkg::ST_OK},
			'{1'b0, 32'h0, 32'h0, ffat_pkg::OP_ALLOC, 32'h8000_0000, 32'h0, 1'b0, 32'h0,
				ffat_pkg::ST_OK}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (steps[i]) begin
			row = steps[i];
			if (row.reheap) begin
				quiesce(SETTLE_CYCLES);
				write_heap(row.base, row.limit);
			end
			push_item(row.op, row.size, row.ptr, row.typed, '{row.want_addr, row.want_st});
		end

		// random phases, each under its own heap setting; the table carries over
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 6)
				0: begin
					base = $urandom & 32'hFFFF_FFF8;
					sum = {1'b0, base} + $urandom_range(64, 1024);
					limit = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
				1: begin
					// roomy heap with a high allocate rate: drive the table full
					base = '0;
					limit = 32'hFFFF_FFFF;
				end
				2: begin
					base = 32'hFFFF_FF00;
					limit = 32'hFFFF_FFFF;
				end
				3: begin
					base = $urandom;
					sum = {1'b0, base} + $urandom_range(0, 300);
					limit = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
				4: begin
					base = $urandom | 32'h100;
					limit = base - $urandom_range(1, 255);
				end
				default: begin
					base = '0;
					limit = '0;
				end
			endcase
			quiesce(SETTLE_CYCLES);
			write_heap(base, limit);

			span = (limit >= base) ? ({1'b0, limit} - {1'b0, base}) : 33'd64;
			if (span > 33'd4096)
				span = 33'd4096;
			alloc_pct = (ph % 6 == 1) ? 92 : $urandom_range(45, 80);
			hold_at = $urandom_range(10, PHASE_ITEMS - 10);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the sender once per phase until the block has answered everything
				if (i == hold_at)
					quiesce(0);
				r = $urandom_range(0, 99);
				size_req = $urandom;
				ptr = $urandom;
				if (r < alloc_pct) begin
					op = ffat_pkg::OP_ALLOC;
					r = $urandom_range(0, 99);
					if (r < 80)
						size_req = $urandom_range(0, 48);
					else if (r < 95)
						size_req = $urandom_range(0, span[31:0]);
				end else begin
					op = ffat_pkg::OP_FREE;
					r = $urandom_range(0, 99);
					// mostly release live blocks; otherwise near misses and noise
					if (held > 0 && r < 75)
						ptr = blk_start[$urandom_range(0, held - 1)];
					else if (held > 0 && r < 88)
						ptr = blk_start[$urandom_range(0, held - 1)] + $urandom_range(1, 7);
				end
				push_item(op, size_req, ptr, 1'b0, '0);
			end
		end

		quiesce(SETTLE_CYCLES);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== first_fit_allocation_table.f =====
hw/rtl/ffat_pkg.sv
hw/rtl/first_fit_allocation_table.sv
dv/tb_top.sv
